// ----- hw/rtl/sst_pkg.sv -----
`default_nettype none
package sst_pkg;

	localparam int SeqW = 64;

	// request codes
	localparam logic [1:0] REQ_BEGIN    = 2'd0;
	localparam logic [1:0] REQ_SNAPSHOT = 2'd1;
	localparam logic [1:0] REQ_EVENT    = 2'd2;
	localparam logic [1:0] REQ_COMPLETE = 2'd3;

	localparam logic [SeqW-1:0] SEQ_MAX = {SeqW{1'b1}};

	typedef struct packed {
		logic [1:0]      req_type;
		logic [SeqW-1:0] seq_value;
	} cmd_t;

	typedef struct packed {
		logic            accepted;
		logic            can_send;
		logic            resync_required;
		logic [SeqW-1:0] committed_seq;
	} res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sst_core.sv -----
`default_nettype none
module sst_core (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             fire,
	input  sst_pkg::cmd_t   cmd,
	output sst_pkg::res_t   res
);

	logic [sst_pkg::SeqW-1:0] comm_q, pend_q;
	logic                     comm_vld_q, pend_vld_q, sync_q, resync_q;

	logic [sst_pkg::SeqW-1:0] comm_d, pend_d, cur;
	logic                     comm_vld_d, pend_vld_d, sync_d, resync_d, ok;
	logic                     cur_ok, snap_bad, evt_bad;

	// value that an event must follow
	assign cur    = sync_q ? pend_q : comm_q;
	assign cur_ok = sync_q ? pend_vld_q : comm_vld_q;

	assign snap_bad = (cmd.seq_value == '0) || pend_vld_q ||
		(comm_vld_q && (cmd.seq_value < comm_q));
	assign evt_bad  = !cur_ok || resync_q || (cur == sst_pkg::SEQ_MAX) ||
		(cmd.seq_value != cur + sst_pkg::SeqW'(1));

	// next state for the request in hand
	always_comb begin
		comm_d     = comm_q;
		pend_d     = pend_q;
		comm_vld_d = comm_vld_q;
		pend_vld_d = pend_vld_q;
		sync_d     = sync_q;
		resync_d   = resync_q;
		ok         = 1'b0;
		unique case (cmd.req_type)
			sst_pkg::REQ_BEGIN: begin
				sync_d     = 1'b1;
				pend_d     = '0;
				pend_vld_d = 1'b0;
				resync_d   = 1'b0;
				ok         = 1'b1;
			end
			sst_pkg::REQ_SNAPSHOT: begin
				if (sync_q) begin
					if (snap_bad) begin
						resync_d = 1'b1;
					end else begin
						pend_d     = cmd.seq_value;
						pend_vld_d = 1'b1;
						ok         = 1'b1;
					end
				end
			end
			sst_pkg::REQ_EVENT: begin
				if (evt_bad) begin
					resync_d = 1'b1;
				end else begin
					ok = 1'b1;
					if (sync_q) begin
						pend_d = cmd.seq_value;
					end else begin
						comm_d = cmd.seq_value;
					end
				end
			end
			sst_pkg::REQ_COMPLETE: begin
				if (sync_q && pend_vld_q && !resync_q) begin
					comm_d     = pend_q;
					comm_vld_d = 1'b1;
					pend_d     = '0;
					pend_vld_d = 1'b0;
					sync_d     = 1'b0;
					ok         = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// result reflects state after this request
	assign res.accepted        = ok;
	assign res.can_send        = !sync_d && !resync_d;
	assign res.resync_required = resync_d;
	assign res.committed_seq   = comm_vld_d ? comm_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comm_q     <= '0;
			pend_q     <= '0;
			comm_vld_q <= 1'b0;
			pend_vld_q <= 1'b0;
			sync_q     <= 1'b1;
			resync_q   <= 1'b0;
		end else if (fire) begin
			comm_q     <= comm_d;
			pend_q     <= pend_d;
			comm_vld_q <= comm_vld_d;
			pend_vld_q <= pend_vld_d;
			sync_q     <= sync_d;
			resync_q   <= resync_d;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sequence_sync_tracker.sv -----
`default_nettype none
// Sequence sync tracker: follows a snapshot plus incremental-event sequence stream.
// Command channel (cmd, cmd_valid, cmd_stall) carries one request per accepted
// beat: begin sync, apply snapshot, apply event or complete sync.
// Result channel (res, res_valid, res_stall) returns exactly one result per
// request, in order: accepted, can_send, resync_required, committed_seq.
// A request passes through the input register and then the result register.
// Throughput: one request per cycle while res_stall is low; the tracker state
// (committed/pending sequence, valid bits, sync mode, resync flag) is read and
// updated between the input register and the result register.
// When the receiver stalls, the result register holds its payload; an empty input
// register still takes one more request, after which cmd_stall is raised
// until the result is taken.
// Reset (arst_n low) empties both registers, enters sync mode and clears the
// committed and pending values and the resync flag.
module sequence_sync_tracker (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           cmd_valid,
	output logic          cmd_stall,
	input  sst_pkg::cmd_t cmd,
	output logic          res_valid,
	input  wire           res_stall,
	output sst_pkg::res_t res
);

	logic          vld_s1;
	sst_pkg::cmd_t cmd_s1;
	sst_pkg::res_t core_res;
	logic          adv;

	// pipeline moves when the result register is free or being emptied
	assign adv       = !(res_valid && res_stall);
	assign cmd_stall = vld_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	sst_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (vld_s1 && adv),
		.cmd    (cmd_s1),
		.res    (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			res <= core_res;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sst_checker.sv -----
`default_nettype none
module sst_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           res_valid,
	input wire           res_stall,
	input sst_pkg::res_t res
);

	logic                     have_q, last_resync_q;
	logic [sst_pkg::SeqW-1:0] last_comm_q;
	logic                     res_take;

	assign res_take = res_valid && !res_stall;

	// last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q        <= 1'b0;
			last_resync_q <= 1'b0;
			last_comm_q   <= '0;
		end else if (res_take) begin
			have_q        <= 1'b1;
			last_resync_q <= res.resync_required;
			last_comm_q   <= res.committed_seq;
		end
	end

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("result changed while stalled");

	// sending is never permitted while resync is required
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.can_send && res.resync_required))
		else $error("can_send with resync required");

	// a rejected request leaves the committed sequence alone
	a_rej_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(res_take && have_q && !res.accepted) |-> (res.committed_seq == last_comm_q))
		else $error("rejected request changed committed sequence");

	// the resync flag is raised only by a rejected request
	a_rise_rej: assert property (@(posedge clk) disable iff (!arst_n)
		(res_take && have_q && !last_resync_q && res.resync_required) |-> !res.accepted)
		else $error("resync raised by accepted request");

endmodule

bind sequence_sync_tracker sst_checker u_sst_checker (.*);
`default_nettype wire
